// ===== hdl/aptck_pkg.sv =====
package aptck_pkg;

    localparam int ATOM_W = 7;
    localparam int DIST_W = 7;
    localparam int IDX_W  = 3;
    localparam int CODE_W = 10;
    localparam int KEY_W  = 26;

    // Only values that fit ATOM_W can arrive, so the upper bound never trips.
    localparam int MAX_ATOMIC_NUMBER = 127;

    localparam logic [DIST_W-1:0] TRIPLE_DIST_MAX = DIST_W'(39);

    localparam logic [KEY_W-1:0] PAIR_LOW_MULT    = KEY_W'(1000);
    localparam logic [KEY_W-1:0] PAIR_DIST_MULT   = KEY_W'(10);
    localparam logic [KEY_W-1:0] TRIPLE_CODE_MULT = KEY_W'(100000);
    localparam logic [KEY_W-1:0] TRIPLE_D12_MULT  = KEY_W'(1600);
    localparam logic [KEY_W-1:0] TRIPLE_D13_MULT  = KEY_W'(40);
    localparam logic [KEY_W-1:0] KEY_MAX          = KEY_W'(55563999);

    localparam logic [CODE_W-1:0] CODE_HUNDREDS = CODE_W'(100);
    localparam logic [CODE_W-1:0] CODE_TENS     = CODE_W'(10);

    typedef enum logic {
        CMD_PAIR   = 1'b0,
        CMD_TRIPLE = 1'b1
    } cmd_t;

    typedef enum logic [IDX_W-1:0] {
        IDX_NONE = 3'd0,
        IDX_C    = 3'd1,
        IDX_N    = 3'd2,
        IDX_O    = 3'd3,
        IDX_P    = 3'd4,
        IDX_S    = 3'd5
    } atom_idx_t;

    // 0 means unmapped
    function automatic logic [IDX_W-1:0] atom_index(input logic [ATOM_W-1:0] z);
        logic [IDX_W-1:0] idx;
        idx = IDX_NONE;
        if (int'(z) <= MAX_ATOMIC_NUMBER) begin
            case (z)
                ATOM_W'(6):  idx = IDX_C;
                ATOM_W'(7):  idx = IDX_N;
                ATOM_W'(8):  idx = IDX_O;
                ATOM_W'(15): idx = IDX_P;
                ATOM_W'(16): idx = IDX_S;
                default:     idx = IDX_NONE;
            endcase
        end
        return idx;
    endfunction

endpackage

// ===== hdl/atom_pair_triple_canonical_key.sv =====
// Canonical atom pair/triple key generator. Takes one tuple per clock unless the
// output side stalls, and returns one result per tuple, in order. A result passes
// through one input register, then the index mapping, the three-compare sort with
// distance permutation and the constant-multiply packing, then the result register.
// Both stages advance independently, so a full rate stream runs with no bubbles
// while m_ready stays high; s_ready follows m_ready combinationally when both
// stages are occupied.
module atom_pair_triple_canonical_key (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                s_valid,
    output logic                                s_ready,
    input  logic                                s_command,
    input  logic [aptck_pkg::ATOM_W-1:0]        s_atom_a,
    input  logic [aptck_pkg::ATOM_W-1:0]        s_atom_b,
    input  logic [aptck_pkg::ATOM_W-1:0]        s_atom_c,
    input  logic [aptck_pkg::DIST_W-1:0]        s_dist_ab,
    input  logic [aptck_pkg::DIST_W-1:0]        s_dist_ac,
    input  logic [aptck_pkg::DIST_W-1:0]        s_dist_bc,
    output logic                                m_valid,
    input  logic                                m_ready,
    output logic [aptck_pkg::KEY_W-1:0]         m_key,
    output logic                                m_invalid
);

    logic                              in_valid_reg;
    logic                              cmd_reg;
    logic [aptck_pkg::ATOM_W-1:0]      atom_a_reg, atom_b_reg, atom_c_reg;
    logic [aptck_pkg::DIST_W-1:0]      dist_ab_reg, dist_ac_reg, dist_bc_reg;

    logic                              out_valid_reg;
    logic [aptck_pkg::KEY_W-1:0]       key_reg, key_next;
    logic                              invalid_reg, invalid_next;

    logic out_load;
    logic in_load;

    assign out_load = !out_valid_reg || m_ready;
    assign s_ready  = !in_valid_reg || out_load;
    assign in_load  = s_valid && s_ready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_ready) begin
            in_valid_reg <= s_valid;
        end
        if (in_load) begin
            cmd_reg     <= s_command;
            atom_a_reg  <= s_atom_a;
            atom_b_reg  <= s_atom_b;
            atom_c_reg  <= s_atom_c;
            dist_ab_reg <= s_dist_ab;
            dist_ac_reg <= s_dist_ac;
            dist_bc_reg <= s_dist_bc;
        end
    end

    always_comb begin
        logic [aptck_pkg::IDX_W-1:0]  i1, i2, i3, it;
        logic [aptck_pkg::DIST_W-1:0] d12, d13, d23, dt;
        logic [aptck_pkg::CODE_W-1:0] code;
        logic                         bad;

        i1  = aptck_pkg::atom_index(atom_a_reg);
        i2  = aptck_pkg::atom_index(atom_b_reg);
        i3  = aptck_pkg::atom_index(atom_c_reg);
        d12 = dist_ab_reg;
        d13 = dist_ac_reg;
        d23 = dist_bc_reg;
        it = '0;
        dt = '0;
        key_next = '0;
        bad = 1'b0;
        code = '0;

        if (cmd_reg == aptck_pkg::CMD_PAIR) begin
            bad = (i1 == aptck_pkg::IDX_NONE) || (i2 == aptck_pkg::IDX_NONE);
            if (i1 > i2) begin
                it = i1; i1 = i2; i2 = it;
            end
            key_next = aptck_pkg::KEY_W'(i1) * aptck_pkg::PAIR_LOW_MULT
                     + aptck_pkg::KEY_W'(d12) * aptck_pkg::PAIR_DIST_MULT
                     + aptck_pkg::KEY_W'(i2);
        end else begin
            bad = (i1 == aptck_pkg::IDX_NONE) || (i2 == aptck_pkg::IDX_NONE)
               || (i3 == aptck_pkg::IDX_NONE)
               || (d12 > aptck_pkg::TRIPLE_DIST_MAX)
               || (d13 > aptck_pkg::TRIPLE_DIST_MAX)
               || (d23 > aptck_pkg::TRIPLE_DIST_MAX);

            // sort indices; each swap carries the distances to the moved atoms
            if (i1 > i2) begin
                it = i1; i1 = i2; i2 = it;
                dt = d13; d13 = d23; d23 = dt;
            end
            if (i2 > i3) begin
                it = i2; i2 = i3; i3 = it;
                dt = d12; d12 = d13; d13 = dt;
            end
            if (i1 > i2) begin
                it = i1; i1 = i2; i2 = it;
                dt = d13; d13 = d23; d23 = dt;
            end

            // tie-break on distances made interchangeable by equal indices
            if (i1 == i2 && i2 == i3) begin
                if (d12 > d13) begin dt = d12; d12 = d13; d13 = dt; end
                if (d13 > d23) begin dt = d13; d13 = d23; d23 = dt; end
                if (d12 > d13) begin dt = d12; d12 = d13; d13 = dt; end
            end else if (i1 == i2) begin
                if (d13 > d23) begin dt = d13; d13 = d23; d23 = dt; end
            end else if (i2 == i3) begin
                if (d12 > d13) begin dt = d12; d12 = d13; d13 = dt; end
            end

            code = aptck_pkg::CODE_W'(i1) * aptck_pkg::CODE_HUNDREDS
                 + aptck_pkg::CODE_W'(i2) * aptck_pkg::CODE_TENS
                 + aptck_pkg::CODE_W'(i3);
            key_next = aptck_pkg::KEY_W'(code) * aptck_pkg::TRIPLE_CODE_MULT
                     + aptck_pkg::KEY_W'(d12) * aptck_pkg::TRIPLE_D12_MULT
                     + aptck_pkg::KEY_W'(d13) * aptck_pkg::TRIPLE_D13_MULT
                     + aptck_pkg::KEY_W'(d23);
        end

        if (bad) begin
            key_next = '0;
        end
        invalid_next = bad;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (out_load) begin
            out_valid_reg <= in_valid_reg;
        end
        if (out_load && in_valid_reg) begin
            key_reg     <= key_next;
            invalid_reg <= invalid_next;
        end
    end

    assign m_valid   = out_valid_reg;
    assign m_key     = key_reg;
    assign m_invalid = invalid_reg;

endmodule

// ===== hdl/aptck_checker.sv =====
module aptck_checker (
    input logic                          aclk,
    input logic                          aresetn,
    input logic                          s_valid,
    input logic                          s_ready,
    input logic                          m_valid,
    input logic                          m_ready,
    input logic [aptck_pkg::KEY_W-1:0]   m_key,
    input logic                          m_invalid
);

    // flagged results always carry a zero key
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_invalid |-> m_key == '0)
        else $error("invalid result with nonzero key");

    assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> m_key <= aptck_pkg::KEY_MAX)
        else $error("key out of range");

    // a draining output side never stalls the input side
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_ready |-> s_ready)
        else $error("input stalled while output drains");

    assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_key) && $stable(m_invalid))
        else $error("result changed before transfer");

    // no result is valid right after reset
    assert property (@(posedge aclk)
        !aresetn |=> !m_valid)
        else $error("result valid right after reset");

endmodule

bind atom_pair_triple_canonical_key aptck_checker u_aptck_checker (
    .aclk      (aclk),
    .aresetn   (aresetn),
    .s_valid   (s_valid),
    .s_ready   (s_ready),
    .m_valid   (m_valid),
    .m_ready   (m_ready),
    .m_key     (m_key),
    .m_invalid (m_invalid)
);
